### hw/rtl/ebr_pkg.sv
// Package for the encoder error bin recorder: sizes, codes, and the
// command/status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ebr_pkg;

	localparam int TBL_BINS   = 4096;
	localparam int COUNT_BITS = 24;
	localparam int ADDR_W     = $clog2(TBL_BINS);
	localparam int BIN_W      = 12;
	localparam int SUM_W      = 32;
	localparam int CORR_W     = 16;
	localparam int STEP_W     = $clog2(SUM_W);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [CORR_W-1:0]     CORR_MAX  = CORR_W'(32767);
	localparam logic [CORR_W-1:0]     NO_DATA   = CORR_W'(16'h8000);

	typedef enum logic [1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_READ   = 2'd1,
		FUNC_CLEAR  = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		RES_PLAIN,
		RES_CLOSED,
		RES_READ
	} res_kind_t;

	typedef struct packed {
		logic      load_item;
		logic      acc;
		logic      div_start;
		logic      close;
		logic      rd_en;
		logic      sweep_wr;
		logic      load_out;
		res_kind_t res_kind;
	} ebr_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       bin_diff;
		logic       div_done;
		logic       sweep_last;
	} ebr_sts_t;

endpackage

`default_nettype wire

### hw/rtl/ebr_ifs.sv
// Channel interfaces of the encoder error bin recorder: the item channel
// and the result channel. Depends on ebr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ebr_item_if;
	import ebr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                func;
	logic signed [SUM_W-1:0]   motor_counts;
	logic signed [SUM_W-1:0]   encoder_counts;
	logic [BIN_W-1:0]          bin_index;
	logic [BIN_W-1:0]          read_index;

	modport source (output valid, func, motor_counts, encoder_counts, bin_index,
		read_index, input ready);
	modport sink (input valid, func, motor_counts, encoder_counts, bin_index,
		read_index, output ready);
endinterface

interface ebr_result_if;
	import ebr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [CORR_W-1:0]  correction;
	logic                      bin_closed;
	logic signed [CORR_W-1:0]  read_data;

	modport source (output valid, correction, bin_closed, read_data, input ready);
	modport sink (input valid, correction, bin_closed, read_data, output ready);
endinterface

`default_nettype wire

### hw/rtl/ebr_div.sv
// Radix-2 restoring divider: signed sum over unsigned count, quotient
// truncated toward zero, one quotient bit per cycle. Depends on ebr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ebr_div (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	input  wire [ebr_pkg::SUM_W-1:0]       dividend,
	input  wire [ebr_pkg::COUNT_BITS-1:0]  divisor,
	output logic                           done,
	output logic [ebr_pkg::SUM_W-1:0]      quo_mag,
	output logic                           quo_neg
);
	import ebr_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [SUM_W-1:0]      quo_q;
	logic [COUNT_BITS-1:0] dvs_q;
	logic                  neg_q;

	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  ge;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register shifts out magnitude bits and shifts in quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			quo_q <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[SUM_W-2:0], ge};
		end
	end

	assign done    = done_q;
	assign quo_mag = quo_q;
	assign quo_neg = neg_q;

endmodule

`default_nettype wire

### hw/rtl/ebr_dpath.sv
// Datapath of the encoder error bin recorder: item register, running sum and
// count, divider, clamp, correction table memory and result register.
// Depends on ebr_pkg and ebr_div.
`timescale 1ns / 1ps
`default_nettype none

module ebr_dpath (
	input  wire                          clk,
	input  wire                          arst_n,
	input  ebr_pkg::ebr_cmd_t            cmd,
	output ebr_pkg::ebr_sts_t            sts,
	input  wire [1:0]                    func,
	input  wire [ebr_pkg::SUM_W-1:0]     motor_counts,
	input  wire [ebr_pkg::SUM_W-1:0]     encoder_counts,
	input  wire [ebr_pkg::BIN_W-1:0]     bin_index,
	input  wire [ebr_pkg::BIN_W-1:0]     read_index,
	output logic [ebr_pkg::CORR_W-1:0]   correction,
	output logic                         bin_closed,
	output logic [ebr_pkg::CORR_W-1:0]   read_data
);
	import ebr_pkg::*;

	logic [1:0]            func_q;
	logic [SUM_W-1:0]      motor_q;
	logic [SUM_W-1:0]      enc_q;
	logic [BIN_W-1:0]      bin_q;
	logic [BIN_W-1:0]      ridx_q;

	logic [SUM_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [BIN_W-1:0]      prev_bin_q;
	logic [CORR_W-1:0]     latest_q;
	logic [ADDR_W-1:0]     sweep_q;

	logic [CORR_W-1:0]     mem [TBL_BINS];
	logic [CORR_W-1:0]     rd_q;

	logic [CORR_W-1:0]     corr_q;
	logic                  closed_q;
	logic [CORR_W-1:0]     rdata_q;

	logic                  div_done;
	logic [SUM_W-1:0]      quo_mag;
	logic                  quo_neg;
	logic [CORR_W-1:0]     mag_sat;
	logic [CORR_W-1:0]     clamped;
	logic                  store_ok;
	logic                  ridx_ok;
	logic                  sweep_last;

	ebr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quo_mag  (quo_mag),
		.quo_neg  (quo_neg)
	);

	// Quotient magnitude is clamped before the sign goes back on, so the
	// result lands in -32767..32767 and never collides with the no-data code.
	assign mag_sat  = (quo_mag > SUM_W'(CORR_MAX)) ? CORR_MAX : quo_mag[CORR_W-1:0];
	assign clamped  = quo_neg ? (~mag_sat + CORR_W'(1)) : mag_sat;
	assign store_ok = (prev_bin_q != '0) && (32'(prev_bin_q) < TBL_BINS);
	assign ridx_ok  = (32'(ridx_q) < TBL_BINS);
	assign sweep_last = (sweep_q == ADDR_W'(TBL_BINS - 1));

	assign sts.func       = func_q;
	assign sts.bin_diff   = (bin_q != prev_bin_q);
	assign sts.div_done   = div_done;
	assign sts.sweep_last = sweep_last;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			func_q  <= func;
			motor_q <= motor_counts;
			enc_q   <= encoder_counts;
			bin_q   <= bin_index;
			ridx_q  <= read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			count_q    <= '0;
			prev_bin_q <= '0;
			latest_q   <= '0;
			sweep_q    <= '0;
		end else begin
			if (cmd.acc) begin
				sum_q <= sum_q + (motor_q - enc_q);
				if (count_q != COUNT_MAX) begin
					count_q <= count_q + COUNT_BITS'(1);
				end
			end
			if (cmd.close) begin
				latest_q   <= clamped;
				sum_q      <= '0;
				count_q    <= '0;
				prev_bin_q <= bin_q;
			end
			if (cmd.sweep_wr) begin
				sweep_q <= sweep_last ? '0 : sweep_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_wr) begin
			mem[sweep_q] <= NO_DATA;
		end else if (cmd.close && store_ok) begin
			mem[ADDR_W'(prev_bin_q)] <= clamped;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_q <= mem[ADDR_W'(ridx_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			corr_q   <= latest_q;
			closed_q <= (cmd.res_kind == RES_CLOSED);
			if (cmd.res_kind == RES_READ) begin
				rdata_q <= ridx_ok ? rd_q : NO_DATA;
			end else begin
				rdata_q <= '0;
			end
		end
	end

	assign correction = corr_q;
	assign bin_closed = closed_q;
	assign read_data  = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/ebr_ctrl.sv
// Controller of the encoder error bin recorder: sequences each item, the
// table clearing sweeps and both channel handshakes. Depends on ebr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ebr_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  wire                 result_ready,
	input  wire                 cfg_we,
	input  wire                 cfg_wdata,
	output ebr_pkg::ebr_cmd_t   cmd,
	input  ebr_pkg::ebr_sts_t   sts
);
	import ebr_pkg::*;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_ACC,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_CLOSE,
		ST_READ,
		ST_CLEAR,
		ST_RESULT
	} state_t;

	state_t    state_q;
	logic      out_valid_q;
	logic      enable_q;
	res_kind_t kind_q;
	logic      out_free;

	assign out_free = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
			enable_q    <= 1'b1;
			kind_q      <= RES_PLAIN;
		end else begin
			if (cfg_we) begin
				enable_q <= cfg_wdata;
			end
			// A result taken by the receiver frees the output register unless a
			// new result is loaded at the same edge.
			if (result_ready && !cmd.load_out) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					if (sts.sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					kind_q <= RES_PLAIN;
					if (sts.func == FUNC_SAMPLE && enable_q) begin
						state_q <= ST_ACC;
					end else if (sts.func == FUNC_READ) begin
						state_q <= ST_READ;
					end else if (sts.func == FUNC_CLEAR) begin
						state_q <= ST_CLEAR;
					end else begin
						state_q <= ST_RESULT;
					end
				end
				ST_ACC: begin
					state_q <= sts.bin_diff ? ST_DIV_START : ST_RESULT;
				end
				ST_DIV_START: begin
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (sts.div_done) begin
						state_q <= ST_CLOSE;
					end
				end
				ST_CLOSE: begin
					kind_q  <= RES_CLOSED;
					state_q <= ST_RESULT;
				end
				ST_READ: begin
					kind_q  <= RES_READ;
					state_q <= ST_RESULT;
				end
				ST_CLEAR: begin
					if (sts.sweep_last) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd.load_item = (state_q == ST_IDLE) && item_valid;
		cmd.acc       = (state_q == ST_ACC);
		cmd.div_start = (state_q == ST_DIV_START);
		cmd.close     = (state_q == ST_CLOSE);
		cmd.rd_en     = (state_q == ST_READ);
		cmd.sweep_wr  = (state_q == ST_INIT) || (state_q == ST_CLEAR);
		cmd.load_out  = (state_q == ST_RESULT) && out_free;
		cmd.res_kind  = kind_q;
	end

	assign item_ready   = (state_q == ST_IDLE);
	assign result_valid = out_valid_q;

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INIT || state_q == ST_CLEAR) |-> !item_ready)
		else $error("item taken during a table clearing sweep");

	a_div_done_when_waited: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_DIV_WAIT))
		else $error("divider finished while the controller was not waiting on it");

	a_close_follows_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE) |-> $past(sts.div_done))
		else $error("bin closed without a fresh quotient");

endmodule

`default_nettype wire

### hw/rtl/encoder_error_bin_recorder_top.sv
// Top level of the encoder error bin recorder: joins the controller and the
// datapath to the item and result channels and the configuration port.
// Depends on ebr_pkg, ebr_ifs, ebr_ctrl, ebr_dpath and ebr_div.
//
// Usage: items arrive on the item channel and each one yields exactly one
// result transfer on the result channel. An enabled sample item adds motor minus
// encoder counts to a running sum; when its bin differs from the previous
// one, the sum is divided by the sample count, clamped to +/-32767, and
// written to the table entry of the previous bin (bin 0 is never stored).
// A read item returns one table entry (-32768 means no data), and a clear
// item marks the whole table as no-data.
// From the accepted transfer, an ignored item goes through decode to the
// result state; a plain sample adds an accumulate step and a read a table
// read; a sample that closes a bin also runs the one-bit-per-cycle divider
// over 32 quotient bits and a close step. A clear item sweeps the table, one
// table entry written per cycle. The item channel is ready again in the cycle
// after the result is loaded.
// One item is in flight at a time; the next one may be taken while the
// previous result still waits in the output register.
// After reset the whole table is swept to no-data while item ready is
// low; configuration writes are taken at any time. A stalled receiver holds
// the result in the output register and the block finishes its current item
// before waiting on the output.
`timescale 1ns / 1ps
`default_nettype none

module encoder_error_bin_recorder_top (
	input  wire          clk,
	input  wire          arst_n,
	ebr_item_if.sink     item,
	ebr_result_if.source result,
	input  wire          cfg_we,
	input  wire          cfg_wdata
);
	import ebr_pkg::*;

	ebr_cmd_t          cmd;
	ebr_sts_t          sts;
	logic              item_ready;
	logic              result_valid;
	logic [CORR_W-1:0] correction;
	logic              bin_closed;
	logic [CORR_W-1:0] read_data;

	// The controller owns both handshakes and the enable register.
	ebr_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result.ready),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts)
	);

	// The datapath holds the item, the accumulators, the table and the
	// result register.
	ebr_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.func           (item.func),
		.motor_counts   (item.motor_counts),
		.encoder_counts (item.encoder_counts),
		.bin_index      (item.bin_index),
		.read_index     (item.read_index),
		.correction     (correction),
		.bin_closed     (bin_closed),
		.read_data      (read_data)
	);

	assign item.ready        = item_ready;
	assign result.valid      = result_valid;
	assign result.correction = correction;
	assign result.bin_closed = bin_closed;
	assign result.read_data  = read_data;

endmodule

`default_nettype wire
